// File: design/mmts_pkg.sv
package mmts_pkg;

  // Operation codes carried by the kind field.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Status codes of a result beat.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 11;

  // One stack entry: the value and the running min and max up to it.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] min;
    logic signed [DataW-1:0] max;
  } entry_t;

  // One result beat.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] min;
    logic signed [DataW-1:0] max;
    logic [CountW-1:0]       count;
    logic [1:0]              status;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // Finish a push, read, empty access or a pop of the last entry.
    logic pop_rd;    // Start a pop that needs the entry below the top from memory.
    logic pop_load;  // Finish that pop with the memory read data.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic multi;     // At least two entries are held.
  } dp_stat_t;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE     = 2'b01,
    ST_POP_WAIT = 2'b10
  } state_e;

endpackage

// File: design/mmts_ram.sv
module mmts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mmts_ctrl.sv
module mmts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  mmts_pkg::dp_stat_t  stat_i,
  output mmts_pkg::ctrl_cmd_t cmd_o
);
  import mmts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;
  logic   long_pop;

  // The result register is free when empty or when its beat leaves this cycle.
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign long_pop   = (kind_i == KIND_POP) && stat_i.multi;

  // Command decode and next state.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (long_pop) begin
            cmd_o.pop_rd = 1'b1;
            state_d      = ST_POP_WAIT;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      ST_POP_WAIT: begin
        cmd_o.pop_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set when a result is loaded, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec || cmd_o.pop_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A pop waiting on memory always finds the result register free.
  a_wait_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_WAIT) |-> !out_valid_q)
    else $error("pop wait entered while a result was pending");

  // The memory wait ends with a return to idle and a result.
  a_wait_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_WAIT) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("pop wait did not finish with a result");

  // No beat is accepted unless its result has room.
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> slot_free)
    else $error("beat accepted while the result register was blocked");

endmodule

// File: design/mmts_dp.sv
module mmts_dp #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mmts_pkg::ctrl_cmd_t        cmd_i,
  output mmts_pkg::dp_stat_t         stat_o,
  input  logic [1:0]                 kind_i,
  input  logic signed [31:0]         push_value_i,
  output logic signed [31:0]         item_value_o,
  output logic signed [31:0]         min_value_o,
  output logic signed [31:0]         max_value_o,
  output logic [10:0]                entry_count_o,
  output logic [1:0]                 status_o
);
  import mmts_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [CntW-1:0]        cnt_m2;
  logic [CntW+CountW-1:0] cnt_ext;
  entry_t                 top_q, top_d;
  result_t                res_q, res_d;
  entry_t                 push_entry;
  entry_t                 rd_entry;
  logic [$bits(entry_t)-1:0] rdata;
  logic                   full;
  logic                   ram_we;

  assign full     = (cnt_q == CntW'(STACK_DEPTH));
  assign cnt_m2   = cnt_q - CntW'(2);
  assign rd_entry = entry_t'(rdata);
  assign stat_o.multi = (cnt_q > CntW'(1));

  // New entry for a push: running min and max against the current top.
  always_comb begin
    push_entry.value = push_value_i;
    push_entry.min   = push_value_i;
    push_entry.max   = push_value_i;
    if (cnt_q != '0) begin
      if (top_q.min < push_value_i) begin
        push_entry.min = top_q.min;
      end
      if (top_q.max > push_value_i) begin
        push_entry.max = top_q.max;
      end
    end
  end

  assign ram_we = cmd_i.exec && (kind_i == KIND_PUSH) && !full;

  // Entry store; the top entry also lives in top_q.
  mmts_ram #(
    .Width ($bits(entry_t)),
    .Depth (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (push_entry),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (cnt_m2[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Operation execution and result formation.
  always_comb begin
    cnt_d   = cnt_q;
    top_d   = top_q;
    res_d   = res_q;
    cnt_ext = '0;
    if (cmd_i.exec) begin
      case (kind_i)
        KIND_PUSH: begin
          if (full) begin
            res_d.value  = top_q.value;
            res_d.min    = top_q.min;
            res_d.max    = top_q.max;
            res_d.status = STATUS_OVERFLOW;
          end else begin
            top_d        = push_entry;
            cnt_d        = cnt_q + CntW'(1);
            res_d.value  = push_entry.value;
            res_d.min    = push_entry.min;
            res_d.max    = push_entry.max;
            res_d.status = STATUS_OK;
          end
        end
        KIND_POP: begin
          if (cnt_q == '0) begin
            res_d.value  = '0;
            res_d.min    = '0;
            res_d.max    = '0;
            res_d.status = STATUS_EMPTY;
          end else begin
            // Pop of the last entry; longer pops take the memory path.
            cnt_d        = cnt_q - CntW'(1);
            res_d.value  = top_q.value;
            res_d.min    = '0;
            res_d.max    = '0;
            res_d.status = STATUS_OK;
          end
        end
        default: begin
          // Read, and the spare code behaves as a read.
          if (cnt_q == '0) begin
            res_d.value  = '0;
            res_d.min    = '0;
            res_d.max    = '0;
            res_d.status = STATUS_EMPTY;
          end else begin
            res_d.value  = top_q.value;
            res_d.min    = top_q.min;
            res_d.max    = top_q.max;
            res_d.status = STATUS_OK;
          end
        end
      endcase
    end
    if (cmd_i.pop_rd) begin
      res_d.value = top_q.value;
      cnt_d       = cnt_q - CntW'(1);
    end
    if (cmd_i.pop_load) begin
      top_d        = rd_entry;
      res_d.min    = rd_entry.min;
      res_d.max    = rd_entry.max;
      res_d.status = STATUS_OK;
    end
    cnt_ext = {{CountW{1'b0}}, cnt_d};
    if (cmd_i.exec || cmd_i.pop_load) begin
      res_d.count = cnt_ext[CountW-1:0];
    end
  end

  // Entry count is control state; top copy and result are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    res_q <= res_d;
  end

  assign item_value_o  = res_q.value;
  assign min_value_o   = res_q.min;
  assign max_value_o   = res_q.max;
  assign entry_count_o = res_q.count;
  assign status_o      = res_q.status;

  // The count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("entry count above capacity");

  // A memory pop only starts with an entry left below the top.
  a_pop_rd_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_rd |=> (cnt_q != '0))
    else $error("memory pop left no entry");

  // An accepted push that fits grows the count by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("push did not grow the count");

endmodule

// File: design/min_max_tracking_stack_core.sv
// Min/max tracking stack.
//
// Input channel (in_valid_i, in_stall_o): each beat carries kind_i (push,
// pop or read) and push_value_i. Output channel (out_valid_o, out_stall_i):
// each input beat gives exactly one result beat with the item value, the
// running minimum and maximum of the entries left, the entry count and a
// status (ok, overflow on a full push, empty on a pop or read with no entries).
//
// Timing: the result is valid the cycle after acceptance for push, read and
// any access that needs no memory read. A pop that leaves entries behind
// reads the next running min/max from the entry memory's registered read port
// and passes through the ST_POP_WAIT state, which stalls the input. Throughput
// is one item per cycle while out_stall_i is low, apart from such pops.
//
// The result sits in an output register; a new beat is taken while the old
// result leaves in the same cycle. While out_stall_i holds a result, the
// input stalls. Reset empties the stack at once; the memory needs no clearing.
module min_max_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic signed [31:0] min_value_o,
  output logic signed [31:0] max_value_o,
  output logic [10:0]        entry_count_o,
  output logic [1:0]         status_o
);
  import mmts_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Handshake and sequencing.
  mmts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Stack storage and result formation.
  mmts_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .kind_i        (kind_i),
    .push_value_i  (push_value_i),
    .item_value_o  (item_value_o),
    .min_value_o   (min_value_o),
    .max_value_o   (max_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule
